@@ sv/umep_pkg.sv @@
`timescale 1ns / 1ps

package umep_pkg;

  // Input item opcodes
  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_WRITE = 2'd1,
    OP_END   = 2'd2
  } op_t;

  localparam logic [7:0] SYSEX_START_BYTE = 8'hF0;
  localparam logic [7:0] SYSEX_END_BYTE   = 8'hF7;
  localparam logic [3:0] CIN_SYSEX_START  = 4'd4;
  localparam logic [3:0] CIN_SYSEX_STOP1  = 4'd5;

  // Slot position counts 0..2
  localparam logic [1:0] PHASE_FIRST = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_LAST  = 2'd2;

  // One USB-MIDI event packet
  typedef struct packed {
    logic [7:0] event_header;
    logic [7:0] data_one;
    logic [7:0] data_two;
    logic [7:0] data_three;
  } pkt_t;

  // Result of one item from the packer core
  typedef struct packed {
    logic vld;
    pkt_t pkt;
  } res_t;

endpackage

@@ sv/umep_in_if.sv @@
`timescale 1ns / 1ps

interface umep_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink (input valid, opcode, value, output ready);
endinterface

@@ sv/umep_out_if.sv @@
`timescale 1ns / 1ps

interface umep_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] event_header;
  logic [7:0] data_one;
  logic [7:0] data_two;
  logic [7:0] data_three;

  modport source (output valid, event_header, data_one, data_two, data_three, input ready);
  modport sink (input valid, event_header, data_one, data_two, data_three, output ready);
endinterface

@@ sv/umep_cfg_if.sv @@
`timescale 1ns / 1ps

interface umep_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/umep_core.sv @@
`timescale 1ns / 1ps

module umep_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          cable,
  input  logic                acc,
  input  logic [1:0]          opcode,
  input  logic [7:0]          value,
  output umep_pkg::res_t      res
);
  import umep_pkg::*;

  logic       sysex_r, sysex_nxt;
  logic [7:0] hdr_r, hdr_nxt;
  logic [7:0] s0_r, s0_nxt;
  logic [7:0] s1_r, s1_nxt;
  logic [7:0] s2_r, s2_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       full_r, full_nxt;
  logic       emit;

  // Next state and result for the item at the input
  always_comb begin
    sysex_nxt = sysex_r;
    hdr_nxt   = hdr_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    phase_nxt = phase_r;
    full_nxt  = full_r;
    emit      = 1'b0;
    case (opcode)
      OP_BEGIN: begin
        sysex_nxt = (value == SYSEX_START_BYTE);
        hdr_nxt   = {cable, value[7:4]};
        phase_nxt = PHASE_FIRST;
        full_nxt  = 1'b0;
      end
      OP_WRITE: begin
        if (!sysex_r) begin
          // plain message: fill slots once, drop extras
          if (!full_r) begin
            case (phase_r)
              PHASE_FIRST:  s0_nxt = value;
              PHASE_SECOND: s1_nxt = value;
              default: begin
                s2_nxt   = value;
                full_nxt = 1'b1;
              end
            endcase
          end
        end else if (value == SYSEX_START_BYTE) begin
          hdr_nxt = {cable, CIN_SYSEX_START};
          s0_nxt  = value;
        end else begin
          if (value == SYSEX_END_BYTE) begin
            hdr_nxt = {cable, CIN_SYSEX_STOP1 + {2'b00, phase_r}};
          end
          case (phase_r)
            PHASE_FIRST: begin
              s0_nxt = value;
              s1_nxt = 8'h00;
              s2_nxt = 8'h00;
            end
            PHASE_SECOND: begin
              s1_nxt = value;
              s2_nxt = 8'h00;
            end
            default: begin
              s2_nxt = value;
              emit   = (value != SYSEX_END_BYTE);
            end
          endcase
        end
        phase_nxt = (phase_r == PHASE_LAST) ? PHASE_FIRST : phase_r + 2'd1;
      end
      OP_END: emit = 1'b1;
      default: ;
    endcase
  end

  // Packet reflects the state after this item
  assign res.vld              = acc & emit;
  assign res.pkt.event_header = hdr_nxt;
  assign res.pkt.data_one     = s0_nxt;
  assign res.pkt.data_two     = s1_nxt;
  assign res.pkt.data_three   = s2_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sysex_r <= 1'b0;
      hdr_r   <= 8'h00;
      s0_r    <= 8'h00;
      s1_r    <= 8'h00;
      s2_r    <= 8'h00;
      phase_r <= PHASE_FIRST;
      full_r  <= 1'b0;
    end else if (acc) begin
      sysex_r <= sysex_nxt;
      hdr_r   <= hdr_nxt;
      s0_r    <= s0_nxt;
      s1_r    <= s1_nxt;
      s2_r    <= s2_nxt;
      phase_r <= phase_nxt;
      full_r  <= full_nxt;
    end
  end

endmodule

@@ sv/usb_midi_event_packer.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Payload                                           Handshake
// in_ch    in   opcode[1:0], value[7:0]                           valid/ready
// out_ch   out  event_header, data_one, data_two, data_three      valid/ready
// cfg_ch   in   data[3:0] = cable_number                          valid/ready
//
// One item per cycle while in_ch is ready; packets are registered on out_ch.
// Synchronous active-low reset clears all packer state and the cable number.
// Output register plus one skid entry: in_ch stalls only while the skid holds
// a packet, that is while the sink stalls with two packets waiting, and for
// the cycle in which the skid entry moves to the output register.
// cfg_ch is always ready.
module usb_midi_event_packer (
  input logic        clk,
  input logic        rst_n,
  umep_in_if.sink    in_ch,
  umep_out_if.source out_ch,
  umep_cfg_if.sink   cfg_ch
);
  import umep_pkg::*;

  logic [3:0] cable_r;
  logic       acc;
  res_t       res;
  logic       out_vld_r;
  pkt_t       out_pkt_r;
  logic       skid_vld_r;
  pkt_t       skid_pkt_r;

  // Configuration register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cable_r <= 4'h0;
    end else if (cfg_ch.valid) begin
      cable_r <= cfg_ch.data;
    end
  end

  assign in_ch.ready = !skid_vld_r;
  assign acc         = in_ch.valid & in_ch.ready;

  umep_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cable  (cable_r),
    .acc    (acc),
    .opcode (in_ch.opcode),
    .value  (in_ch.value),
    .res    (res)
  );

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_ch.ready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (!out_vld_r || out_ch.ready) begin
      out_vld_r <= res.vld;
    end else if (res.vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_ch.ready) begin
        out_pkt_r <= skid_pkt_r;
      end
    end else if (!out_vld_r || out_ch.ready) begin
      out_pkt_r <= res.pkt;
    end else if (res.vld) begin
      skid_pkt_r <= res.pkt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.event_header = out_pkt_r.event_header;
  assign out_ch.data_one     = out_pkt_r.data_one;
  assign out_ch.data_two     = out_pkt_r.data_two;
  assign out_ch.data_three   = out_pkt_r.data_three;

endmodule

@@ tb/midi_packet_checker.sv @@
`timescale 1ns / 1ps

module midi_packet_checker (
  input  logic clk,
  input  logic rst_n,
  umep_in_if   in_ch,
  umep_out_if  out_ch,
  umep_cfg_if  cfg_ch,
  output int   mismatch_count,
  output int   packets_pending
);
  import umep_pkg::*;

  localparam int SHOWN_MISMATCHES = 10;

  // Packer state as the block should hold it
  logic [3:0] cable;
  logic       sysex_on;
  logic [7:0] hdr;
  logic [7:0] slot [3];
  logic [1:0] phase;
  logic       third_done;

  pkt_t expected_packets [$];

  function automatic pkt_t current_packet();
    return {hdr, slot[0], slot[1], slot[2]};
  endfunction

  // Apply one accepted item; queue the packet it emits, if any
  task automatic pack_item(input logic [1:0] op, input logic [7:0] val);
    logic [1:0] pos;
    logic [3:0] cin;
    pos = phase;
    case (op)
      OP_BEGIN: begin
        sysex_on   = (val == SYSEX_START_BYTE);
        hdr        = {cable, val[7:4]};
        phase      = PHASE_FIRST;
        third_done = 1'b0;
      end
      OP_WRITE: begin
        if (!sysex_on) begin
          // plain message: three slots, later bytes dropped
          if (!third_done) begin
            slot[pos] = val;
            if (pos == PHASE_LAST) third_done = 1'b1;
          end
        end else if (val == SYSEX_START_BYTE) begin
          hdr     = {cable, CIN_SYSEX_START};
          slot[0] = val;
        end else begin
          if (val == SYSEX_END_BYTE) begin
            cin = CIN_SYSEX_STOP1 + {2'b00, pos};
            hdr = {cable, cin};
          end
          case (pos)
            PHASE_FIRST: begin
              slot[0] = val;
              slot[1] = 8'h00;
              slot[2] = 8'h00;
            end
            PHASE_SECOND: begin
              slot[1] = val;
              slot[2] = 8'h00;
            end
            default: begin
              slot[2] = val;
              if (val != SYSEX_END_BYTE) expected_packets.push_back(current_packet());
            end
          endcase
        end
        phase = (pos == PHASE_LAST) ? PHASE_FIRST : pos + 2'd1;
      end
      OP_END: expected_packets.push_back(current_packet());
      default: ;
    endcase
  endtask

  task automatic note_failure();
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    pkt_t got;
    pkt_t want;
    if (!rst_n) begin
      cable      = 4'h0;
      sysex_on   = 1'b0;
      hdr        = 8'h00;
      slot[0]    = 8'h00;
      slot[1]    = 8'h00;
      slot[2]    = 8'h00;
      phase      = PHASE_FIRST;
      third_done = 1'b0;
      expected_packets.delete();
    end else begin
      // results first: they belong to items accepted earlier
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.event_header, out_ch.data_one, out_ch.data_two, out_ch.data_three};
        if (expected_packets.size() == 0) begin
          note_failure();
          if (mismatch_count <= SHOWN_MISMATCHES)
            $display("ERROR: unexpected packet %02h %02h %02h %02h at %0t",
                     got.event_header, got.data_one, got.data_two, got.data_three,
                     $realtime);
        end else begin
          want = expected_packets.pop_front();
          if (got.event_header !== want.event_header || got.data_one !== want.data_one ||
              got.data_two !== want.data_two || got.data_three !== want.data_three) begin
            note_failure();
            if (mismatch_count <= SHOWN_MISMATCHES)
              $display({"ERROR: packet mismatch at %0t: header exp %02h got %02h, ",
                        "data_one exp %02h got %02h, data_two exp %02h got %02h, ",
                        "data_three exp %02h got %02h"}, $realtime,
                       want.event_header, got.event_header, want.data_one, got.data_one,
                       want.data_two, got.data_two, want.data_three, got.data_three);
          end
        end
      end
      // an item in the same cycle still sees the old cable number
      if (in_ch.valid && in_ch.ready) pack_item(in_ch.opcode, in_ch.value);
      if (cfg_ch.valid && cfg_ch.ready) cable = cfg_ch.data;
    end
    packets_pending = expected_packets.size();
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import umep_pkg::*;

  // opcode the block ignores
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam int RESET_CYCLES   = 10;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 80;
  localparam int DRAIN_CYCLES   = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  int cycle_count = 0;
  int mismatch_count;
  int packets_pending;
  int items_sent = 0;
  int burst_left = 0;
  int holdoff_req = 0;

  umep_in_if  in_ch ();
  umep_out_if out_ch ();
  umep_cfg_if cfg_ch ();

  usb_midi_event_packer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  midi_packet_checker pkt_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .mismatch_count  (mismatch_count),
    .packets_pending (packets_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Sender: bursts of items with random gaps in between
  task automatic offer(input logic [1:0] op, input logic [7:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= val;
    do @(posedge clk); while (!in_ch.ready);
    if (op != OP_NOP) items_sent++;
  endtask

  // Stop sending and wait until every packet has come out
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (packets_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cable(input logic [3:0] cable);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= cable;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly well-formed channel and SysEx messages, some noise
  task automatic send_messages(input int n_items);
    int target;
    int kind;
    int len;
    int r;
    logic [7:0] status;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        // channel message, sometimes with an odd status
        status = ($urandom_range(0, 7) == 0) ? 8'($urandom) :
                 {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        offer(OP_BEGIN, status);
        len = $urandom_range(0, 5);
        repeat (len) offer(OP_WRITE, 8'($urandom));
        if ($urandom_range(0, 9) != 0) offer(OP_END, 8'($urandom));
      end else if (kind < 85) begin
        // SysEx with 7-bit payload, stray start/end bytes now and then
        offer(OP_BEGIN, SYSEX_START_BYTE);
        len = $urandom_range(0, 10);
        repeat (len) begin
          r = $urandom_range(0, 19);
          if (r == 0) offer(OP_WRITE, SYSEX_START_BYTE);
          else if (r == 1) offer(OP_WRITE, SYSEX_END_BYTE);
          else offer(OP_WRITE, {1'b0, 7'($urandom)});
        end
        if ($urandom_range(0, 4) != 0) offer(OP_WRITE, SYSEX_END_BYTE);
        if ($urandom_range(0, 5) != 0) offer(OP_END, 8'($urandom));
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) offer(2'($urandom_range(0, 3)), 8'($urandom));
      end
    end
  endtask

  // Receiver: stretches of different stall patterns, long hold-off on request
  initial begin
    int mode;
    int len;
    int holdoff_seen;
    holdoff_seen = 0;
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 64);
      for (int k = 0; k < len; k++) begin
        if (holdoff_seen != holdoff_req) begin
          holdoff_seen = holdoff_req;
          out_ch.ready <= 1'b0;
          repeat (HOLDOFF_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= (k % 4 == 0);
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
        @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.opcode <= OP_NOP;
    in_ch.value  <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= 4'h0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_cable(4'hF);
    // end before any begin, then the ignored opcode
    offer(OP_END, 8'h00);
    offer(OP_NOP, 8'hFF);
    // plain message, fourth byte dropped
    offer(OP_BEGIN, 8'h90);
    offer(OP_WRITE, 8'h00);
    offer(OP_WRITE, 8'hFF);
    offer(OP_WRITE, 8'h7F);
    offer(OP_WRITE, 8'h55);
    offer(OP_END, 8'hFF);
    // short message, old slots kept
    offer(OP_BEGIN, 8'hC0);
    offer(OP_WRITE, 8'h12);
    offer(OP_END, 8'h00);
    // SysEx: start byte inside, full packet, end on second slot
    offer(OP_BEGIN, SYSEX_START_BYTE);
    offer(OP_WRITE, SYSEX_START_BYTE);
    offer(OP_WRITE, 8'h01);
    offer(OP_WRITE, 8'h02);
    offer(OP_WRITE, 8'h03);
    offer(OP_WRITE, SYSEX_END_BYTE);
    offer(OP_END, 8'h00);
    // SysEx end on third slot: no packet until end
    offer(OP_BEGIN, SYSEX_START_BYTE);
    offer(OP_WRITE, 8'h10);
    offer(OP_WRITE, 8'h11);
    offer(OP_WRITE, SYSEX_END_BYTE);
    offer(OP_END, 8'h00);
    // begin with a data byte and with the end byte
    offer(OP_BEGIN, 8'h00);
    offer(OP_BEGIN, SYSEX_END_BYTE);
    offer(OP_END, 8'hAA);
    settle();

    set_cable(4'h0);
    send_messages(250);
    settle();

    // long receiver hold-off while the sender keeps going
    set_cable(4'($urandom_range(1, 14)));
    holdoff_req++;
    burst_left = 300;
    send_messages(250);
    settle();

    set_cable(4'($urandom));
    send_messages(250);
    settle();

    if (mismatch_count == 0 && packets_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/umep_pkg.sv
sv/umep_in_if.sv
sv/umep_out_if.sv
sv/umep_cfg_if.sv
sv/umep_core.sv
sv/usb_midi_event_packer.sv
tb/midi_packet_checker.sv
tb/testbench.sv
